### rtl/pfo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pfo_pkg;
   localparam int SampleW  = 16;
   localparam int PhaseW   = 32;
   localparam int FreqW    = 40;
   localparam int SumW     = 42;
   localparam int CordW    = 36;
   localparam int ZW       = 34;
   localparam int Steps    = 28;
   localparam int DivSteps = SumW;
   localparam int MaxAvg   = 1024;
   localparam int AddrW    = 4;
   localparam logic signed [31:0] InvGain = 32'sd652032874;

   typedef enum logic [1:0] {
      REG_MOD_ORDER   = 2'd0,
      REG_AVG_LENGTH  = 2'd1,
      REG_SYMBOL_RATE = 2'd2,
      REG_NONE        = 2'd3
   } reg_idx_type;

   typedef enum logic [3:0] {
      S_IDLE, S_ROT_LD, S_ROT, S_FIN_I, S_FIN_Q, S_VEC_LD, S_VEC,
      S_DIV_LD, S_DIV, S_COMMIT, S_OUT
   } state_type;

   typedef struct packed {
      logic       take;
      logic       rot_load;
      logic       vec_load;
      logic       iter;
      logic       rot_mode;
      logic [4:0] k;
      logic       fin_i;
      logic       fin_q;
      logic       div_load;
      logic       div_step;
      logic       commit;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } status_type;

   // arctangent of 2^-k in 32-bit turns
   function automatic logic [31:0] atan_turn(input logic [4:0] k);
      logic [31:0] r;
      case (k)
         5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
         default: r = 32'h0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

### rtl/pfo_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pfo_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire pfo_pkg::status_type sts,
   output pfo_pkg::cmd_type         cmd
);
   pfo_pkg::state_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic cord_last, div_last;

   assign cord_last = (cnt_ff == 6'(pfo_pkg::Steps - 1));
   assign div_last  = (cnt_ff == 6'(pfo_pkg::DivSteps - 1));
   assign req_stall = (state_ff != pfo_pkg::S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfo_pkg::S_IDLE:   if (req_valid) state_in = pfo_pkg::S_ROT_LD;
         pfo_pkg::S_ROT_LD: state_in = pfo_pkg::S_ROT;
         pfo_pkg::S_ROT:    if (cord_last) state_in = pfo_pkg::S_FIN_I;
         pfo_pkg::S_FIN_I:  state_in = pfo_pkg::S_FIN_Q;
         pfo_pkg::S_FIN_Q:  state_in = pfo_pkg::S_VEC_LD;
         pfo_pkg::S_VEC_LD: state_in = pfo_pkg::S_VEC;
         pfo_pkg::S_VEC:    if (cord_last) state_in = pfo_pkg::S_DIV_LD;
         pfo_pkg::S_DIV_LD: state_in = pfo_pkg::S_DIV;
         pfo_pkg::S_DIV:    if (div_last) state_in = pfo_pkg::S_COMMIT;
         pfo_pkg::S_COMMIT: state_in = pfo_pkg::S_OUT;
         pfo_pkg::S_OUT:    if (!sts.rsp_busy) state_in = pfo_pkg::S_IDLE;
         default:           state_in = pfo_pkg::S_IDLE;
      endcase
   end

   // step counter for cordic and divider
   always_comb begin
      cnt_in = 6'd0;
      if (state_ff == pfo_pkg::S_ROT || state_ff == pfo_pkg::S_VEC ||
          state_ff == pfo_pkg::S_DIV) begin
         cnt_in = (state_in == state_ff) ? cnt_ff + 6'd1 : 6'd0;
      end
   end

   // commands
   always_comb begin
      cmd = '0;
      cmd.k = cnt_ff[4:0];
      case (state_ff)
         pfo_pkg::S_IDLE:   cmd.take = req_valid;
         pfo_pkg::S_ROT_LD: cmd.rot_load = 1'b1;
         pfo_pkg::S_ROT:    begin
            cmd.iter = 1'b1;
            cmd.rot_mode = 1'b1;
         end
         pfo_pkg::S_FIN_I:  cmd.fin_i = 1'b1;
         pfo_pkg::S_FIN_Q:  cmd.fin_q = 1'b1;
         pfo_pkg::S_VEC_LD: cmd.vec_load = 1'b1;
         pfo_pkg::S_VEC:    cmd.iter = 1'b1;
         pfo_pkg::S_DIV_LD: cmd.div_load = 1'b1;
         pfo_pkg::S_DIV:    cmd.div_step = 1'b1;
         pfo_pkg::S_COMMIT: cmd.commit = 1'b1;
         pfo_pkg::S_OUT:    cmd.out_load = !sts.rsp_busy;
         default:           cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfo_pkg::S_IDLE;
         cnt_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule
`default_nettype wire

### rtl/pfo_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module pfo_dp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire pfo_pkg::cmd_type                     cmd,
   output pfo_pkg::status_type                       sts,
   input  wire logic signed [pfo_pkg::SampleW-1:0]   req_in_i,
   input  wire logic signed [pfo_pkg::SampleW-1:0]   req_in_q,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [pfo_pkg::SampleW-1:0]        rsp_out_i,
   output logic signed [pfo_pkg::SampleW-1:0]        rsp_out_q,
   output logic signed [pfo_pkg::FreqW-1:0]          rsp_freq_hz,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [pfo_pkg::AddrW-1:0]            csr_paddr,
   input  wire logic [31:0]                          csr_pwdata,
   output logic [31:0]                               csr_prdata
);
   localparam int XW = pfo_pkg::CordW;
   localparam int ZW = pfo_pkg::ZW;
   localparam int PW = pfo_pkg::PhaseW;
   localparam int SW = pfo_pkg::SampleW;
   localparam int NW = pfo_pkg::SumW;

   // configuration registers
   logic [4:0]  mod_order_ff;
   logic [10:0] avg_length_ff;
   logic [31:0] symbol_rate_ff;
   logic        wr;
   pfo_pkg::reg_idx_type widx;

   // estimator state
   logic [PW-1:0]        derot_phase_ff, norm_freq_ff, prev_angle_ff;
   logic                 prev_zero_ff, cur_zero_ff;
   logic signed [NW-1:0] diff_sum_ff;
   logic [10:0]          diff_count_ff;
   logic signed [SW-1:0] xi_ff, xq_ff;

   // cordic, multiplier, divider
   logic signed [XW-1:0] cx_ff, cy_ff;
   logic signed [ZW-1:0] cz_ff;
   logic [63:0]          fprod_ff;
   logic                 fneg_ff;
   logic [NW-1:0]        dq_ff;
   logic [10:0]          drem_ff, dden_ff;
   logic                 dneg_ff, blk_full_ff;

   // result staging and output
   logic signed [SW-1:0] oi_ff, oq_ff, rsp_i_ff, rsp_q_ff;
   logic signed [pfo_pkg::FreqW-1:0] rsp_f_ff;
   logic                 rsp_valid_ff;

   logic [4:0]  m_eff;
   logic [10:0] n_eff;
   logic        blk_full;

   assign m_eff = (mod_order_ff == 5'd0) ? 5'd1 : mod_order_ff;
   always_comb begin
      if (avg_length_ff == 11'd0) n_eff = 11'd1;
      else if (avg_length_ff > 11'(pfo_pkg::MaxAvg)) n_eff = 11'(pfo_pkg::MaxAvg);
      else n_eff = avg_length_ff;
   end
   assign blk_full = (diff_count_ff >= n_eff);

   assign wr   = csr_psel && csr_penable && csr_pwrite;
   assign widx = pfo_pkg::reg_idx_type'(csr_paddr[3:2]);

   // register read back
   always_comb begin
      case (widx)
         pfo_pkg::REG_MOD_ORDER:   csr_prdata = {27'd0, mod_order_ff};
         pfo_pkg::REG_AVG_LENGTH:  csr_prdata = {21'd0, avg_length_ff};
         pfo_pkg::REG_SYMBOL_RATE: csr_prdata = symbol_rate_ff;
         default:                  csr_prdata = 32'd0;
      endcase
   end

   // frequency magnitude product
   logic signed [PW-1:0] nf_s;
   logic [PW-1:0]        nf_mag;
   assign nf_s   = signed'(norm_freq_ff);
   assign nf_mag = nf_s[PW-1] ? PW'(-nf_s) : norm_freq_ff;

   // saturate the scaled frequency
   logic [39:0] fmag;
   logic signed [pfo_pkg::FreqW-1:0] fsat;
   assign fmag = fprod_ff[63:24];
   always_comb begin
      if (fneg_ff) begin
         fsat = (fmag > 40'h80_0000_0000) ? {1'b1, 39'd0} : -signed'(fmag);
      end else begin
         fsat = (fmag > 40'h7F_FFFF_FFFF) ? {1'b0, {39{1'b1}}} : signed'(fmag);
      end
   end

   // rotation entry: fold phase into the right half plane
   logic [31:0] phi, phi_adj;
   logic        flip;
   logic signed [XW-1:0] xi_w, xq_w;
   assign phi     = derot_phase_ff;
   assign flip    = phi[31] ^ phi[30];
   assign phi_adj = flip ? phi - 32'h8000_0000 : phi;
   assign xi_w    = XW'(xi_ff) <<< (32 - SW);
   assign xq_w    = XW'(xq_ff) <<< (32 - SW);

   // one cordic micro-rotation
   logic sel;
   logic signed [XW-1:0] dx, dy;
   logic signed [ZW-1:0] at;
   assign sel = cmd.rot_mode ? !cz_ff[ZW-1] : (cy_ff <= 0);
   assign dx  = cy_ff >>> cmd.k;
   assign dy  = cx_ff >>> cmd.k;
   assign at  = signed'(ZW'(pfo_pkg::atan_turn(cmd.k)));

   // gain compensation, rounding and saturation
   logic signed [XW+31:0] gprod;
   logic signed [XW+31:0] gsh;
   logic signed [SW-1:0]  gsat;
   assign gprod = (cmd.fin_q ? (XW+32)'(cy_ff) : (XW+32)'(cx_ff)) * (XW+32)'(pfo_pkg::InvGain)
                + ((XW+32)'(1) <<< (61 - SW));
   assign gsh   = gprod >>> (62 - SW);
   always_comb begin
      if (gsh > (XW+32)'((1 <<< (SW-1)) - 1)) gsat = {1'b0, {(SW-1){1'b1}}};
      else if (gsh < -(XW+32)'(1 <<< (SW-1))) gsat = {1'b1, {(SW-1){1'b0}}};
      else gsat = gsh[SW-1:0];
   end

   // phase step of this sample, scaled by M and wrapped
   logic [PW-1:0] cur_angle, dmul;
   logic signed [NW-1:0] dvd;
   logic [NW-1:0] dvd_mag;
   assign cur_angle = cur_zero_ff ? '0 : cz_ff[PW-1:0];
   assign dmul      = PW'((cur_angle - prev_angle_ff) * PW'(m_eff));
   assign dvd       = blk_full ? diff_sum_ff : NW'(signed'(dmul));
   assign dvd_mag   = dvd[NW-1] ? NW'(-dvd) : NW'(dvd);

   // restoring divider step
   logic [11:0] rsh;
   logic        qbit;
   assign rsh  = {drem_ff, dq_ff[NW-1]};
   assign qbit = (rsh >= {1'b0, dden_ff});

   logic signed [NW-1:0] quot;
   assign quot = dneg_ff ? -signed'(dq_ff) : signed'(dq_ff);

   assign sts.rsp_busy = rsp_valid_ff && rsp_stall;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_order_ff   <= 5'd4;
         avg_length_ff  <= 11'd16;
         symbol_rate_ff <= 32'd1000000;
         derot_phase_ff <= '0;
         norm_freq_ff   <= '0;
         prev_angle_ff  <= '0;
         prev_zero_ff   <= 1'b1;
         diff_sum_ff    <= '0;
         diff_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (wr) begin
            case (widx)
               pfo_pkg::REG_MOD_ORDER:   mod_order_ff <= csr_pwdata[4:0];
               pfo_pkg::REG_AVG_LENGTH:  begin
                  avg_length_ff <= csr_pwdata[10:0];
                  diff_sum_ff   <= '0;
                  diff_count_ff <= '0;
               end
               pfo_pkg::REG_SYMBOL_RATE: symbol_rate_ff <= csr_pwdata;
               default:                  ;
            endcase
         end
         if (cmd.take) derot_phase_ff <= derot_phase_ff - norm_freq_ff;
         if (cmd.commit) begin
            if (blk_full_ff) begin
               norm_freq_ff  <= quot[PW-1:0];
               diff_sum_ff   <= '0;
               diff_count_ff <= '0;
            end else begin
               if (!cur_zero_ff && !prev_zero_ff) diff_sum_ff <= diff_sum_ff + quot;
               diff_count_ff <= diff_count_ff + 11'd1;
            end
            prev_angle_ff <= cur_angle;
            prev_zero_ff  <= cur_zero_ff;
         end
         if (cmd.out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath payload
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         xi_ff       <= req_in_i;
         xq_ff       <= req_in_q;
         cur_zero_ff <= (req_in_i == '0) && (req_in_q == '0);
         fprod_ff    <= 64'(nf_mag) * 64'(symbol_rate_ff);
         fneg_ff     <= nf_s[PW-1];
      end
      if (cmd.rot_load) begin
         cx_ff <= flip ? -xi_w : xi_w;
         cy_ff <= flip ? -xq_w : xq_w;
         cz_ff <= ZW'(signed'(phi_adj));
      end else if (cmd.vec_load) begin
         cx_ff <= xi_w[XW-1] ? -xi_w : xi_w;
         cy_ff <= xi_w[XW-1] ? -xq_w : xq_w;
         cz_ff <= xi_w[XW-1] ? ZW'(33'h0_8000_0000) : '0;
      end else if (cmd.iter) begin
         if (sel) begin
            cx_ff <= cx_ff - dx;
            cy_ff <= cy_ff + dy;
            cz_ff <= cz_ff - at;
         end else begin
            cx_ff <= cx_ff + dx;
            cy_ff <= cy_ff - dy;
            cz_ff <= cz_ff + at;
         end
      end
      if (cmd.fin_i) oi_ff <= gsat;
      if (cmd.fin_q) oq_ff <= gsat;
      if (cmd.div_load) begin
         blk_full_ff <= blk_full;
         dq_ff       <= dvd_mag;
         drem_ff     <= '0;
         dneg_ff     <= dvd[NW-1];
         dden_ff     <= blk_full ? n_eff : 11'(m_eff);
      end else if (cmd.div_step) begin
         drem_ff <= qbit ? 11'(rsh - {1'b0, dden_ff}) : rsh[10:0];
         dq_ff   <= {dq_ff[NW-2:0], qbit};
      end
      if (cmd.out_load) begin
         rsp_i_ff <= oi_ff;
         rsp_q_ff <= oq_ff;
         rsp_f_ff <= fsat;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_i   = rsp_i_ff;
   assign rsp_out_q   = rsp_q_ff;
   assign rsp_freq_hz = rsp_f_ff;
endmodule
`default_nettype wire

### rtl/mth_power_freq_offset_estimator_unit.sv
// One item at a time: the input stalls from item accept until the result is staged.
// Each item runs two 28-step passes of the shared CORDIC and a 42-step
// restoring divider before its result is staged. The output register holds a
// result while the next item is accepted.
// Reset: synchronous, active high; registers return to M=4, N=16, 1 MHz.
`timescale 1ns / 1ps
`default_nettype none
module mth_power_freq_offset_estimator_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [pfo_pkg::SampleW-1:0]  req_in_i,
   input  wire logic signed [pfo_pkg::SampleW-1:0]  req_in_q,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [pfo_pkg::SampleW-1:0]       rsp_out_i,
   output logic signed [pfo_pkg::SampleW-1:0]       rsp_out_q,
   output logic signed [pfo_pkg::FreqW-1:0]         rsp_freq_hz,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [pfo_pkg::AddrW-1:0]           csr_paddr,
   input  wire logic [31:0]                         csr_pwdata,
   output logic [31:0]                              csr_prdata,
   output logic                                     csr_pready
);
   pfo_pkg::cmd_type    cmd;
   pfo_pkg::status_type sts;

   assign csr_pready = 1'b1;

   pfo_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .sts(sts), .cmd(cmd)
   );

   pfo_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_in_i(req_in_i), .req_in_q(req_in_q),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_i(rsp_out_i), .rsp_out_q(rsp_out_q), .rsp_freq_hz(rsp_freq_hz),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata)
   );

   // an accepted item blocks the input until its result is staged
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while an item is in work");

   // a fresh result appears only as the controller returns to idle
   a_result_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("result raised outside the final step");
endmodule
`default_nettype wire
